@@ sv/whp_pkg.sv @@
// Shared types and constants of the WAV header parser.
package whp_pkg;

	// Field widths of the request and result channels
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned RATE_W   = 32;

	// Configuration register file
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_MIN_RATE = 1'b0;
	localparam logic        REG_MAX_RATE = 1'b1;
	localparam logic [31:0] MIN_RATE_RST = 32'd8000;
	localparam logic [31:0] MAX_RATE_RST = 32'd48000;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_PARSING = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

	// Rate limits handed from the register file to the parser
	typedef struct packed {
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] max_rate;
	} cfg_t;

endpackage

@@ sv/whp_in_if.sv @@
// Byte request channel: one file byte with its framing flags.
interface whp_in_if;
	logic                         valid;
	logic                         ready;
	logic [whp_pkg::BYTE_W-1:0]   data_byte;
	logic                         first_byte;
	logic                         end_of_stream;

	modport source (output valid, output data_byte, output first_byte,
		output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input first_byte,
		input end_of_stream, output ready);
endinterface

@@ sv/whp_out_if.sv @@
// Result channel: parse status, sample rate and channel mode.
interface whp_out_if;
	logic                         valid;
	logic                         ready;
	logic [whp_pkg::STATUS_W-1:0] status;
	logic [whp_pkg::RATE_W-1:0]   rate_hz;
	logic                         stereo;

	modport source (output valid, output status, output rate_hz,
		output stereo, input ready);
	modport sink (input valid, input status, input rate_hz,
		input stereo, output ready);
endinterface

@@ sv/whp_cfg_regs.sv @@
// APB register file holding the accepted sample rate limits.
module whp_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [whp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [whp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [whp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output whp_pkg::cfg_t                      cfg
);

	logic [whp_pkg::RATE_W-1:0] min_rate_q;
	logic [whp_pkg::RATE_W-1:0] max_rate_q;
	logic                       wr_en;
	logic                       reg_sel;

	// Registers are word spaced; bit 2 picks the register
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= whp_pkg::MIN_RATE_RST;
			max_rate_q <= whp_pkg::MAX_RATE_RST;
		end else if (wr_en) begin
			if (reg_sel == whp_pkg::REG_MIN_RATE) begin
				min_rate_q <= pwdata;
			end else begin
				max_rate_q <= pwdata;
			end
		end
	end

	// Read back
	assign prdata = (reg_sel == whp_pkg::REG_MIN_RATE) ? min_rate_q : max_rate_q;

	assign cfg.min_rate = min_rate_q;
	assign cfg.max_rate = max_rate_q;

endmodule

@@ sv/whp_parser.sv @@
// Byte-wise RIFF/WAVE parse engine: input register, state update, result register.
module whp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  whp_pkg::cfg_t cfg,
	whp_in_if.sink        stream,
	whp_out_if.source     result
);

	typedef enum logic [5:0] {
		PH_RIFF = 6'b000001,
		PH_HDR  = 6'b000010,
		PH_FMT  = 6'b000100,
		PH_SKIP = 6'b001000,
		PH_DONE = 6'b010000,
		PH_ERR  = 6'b100000
	} phase_t;

	localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
	localparam logic [31:0] FMT_LEN   = 32'd16;
	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] BITS_16   = 16'd16;
	localparam logic [15:0] CH_MONO   = 16'd1;
	localparam logic [15:0] CH_STEREO = 16'd2;
	localparam logic [3:0]  RIFF_LAST = 4'd11;
	localparam logic [3:0]  FMT_LAST  = 4'd15;
	localparam logic [2:0]  HDR_LAST  = 3'd7;

	// Expected container header byte at a given offset
	function automatic logic [7:0] riff_want(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h52; // R
			4'd1:    ch = 8'h49; // I
			4'd2:    ch = 8'h46; // F
			4'd3:    ch = 8'h46; // F
			4'd8:    ch = 8'h57; // W
			4'd9:    ch = 8'h41; // A
			4'd10:   ch = 8'h56; // V
			4'd11:   ch = 8'h45; // E
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Input register
	logic                       valid_s1;
	logic [whp_pkg::BYTE_W-1:0] data_byte_s1;
	logic                       first_byte_s1;
	logic                       eos_s1;

	// Parse state
	phase_t      phase_q;
	logic [3:0]  pos_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] skip_q;
	logic [15:0] fmt_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic        seen_q;
	logic        stereo_q;

	// Result register
	logic                         out_valid_q;
	logic [whp_pkg::STATUS_W-1:0] status_q;
	logic [whp_pkg::RATE_W-1:0]   out_rate_q;
	logic                         out_stereo_q;

	// Current (after restart) and next state
	phase_t      cur_phase, nxt_phase;
	logic [3:0]  cur_pos, nxt_pos;
	logic [31:0] cur_tag, nxt_tag;
	logic [31:0] cur_len, nxt_len;
	logic [31:0] cur_skip, nxt_skip;
	logic [15:0] cur_fmt, nxt_fmt;
	logic [15:0] cur_chan, nxt_chan;
	logic [31:0] cur_rate, nxt_rate;
	logic [15:0] cur_bits, nxt_bits;
	logic        cur_seen, nxt_seen;
	logic        cur_stereo, nxt_stereo;
	logic [2:0]  hdr_pos;
	logic [31:0] skip_dec;
	logic        fmt_ok;
	logic [whp_pkg::STATUS_W-1:0] nxt_status;

	logic adv;
	logic in_fire;
	logic s1_fire;

	// Handshake: the result register frees the input register
	assign adv          = !out_valid_q || result.ready;
	assign stream.ready = !valid_s1 || adv;
	assign in_fire      = stream.valid && stream.ready;
	assign s1_fire      = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_byte_s1  <= stream.data_byte;
			first_byte_s1 <= stream.first_byte;
			eos_s1        <= stream.end_of_stream;
		end
	end

	// Per-byte state update
	always_comb begin
		cur_phase  = first_byte_s1 ? PH_RIFF : phase_q;
		cur_pos    = first_byte_s1 ? 4'd0    : pos_q;
		cur_tag    = first_byte_s1 ? 32'd0   : tag_q;
		cur_len    = first_byte_s1 ? 32'd0   : len_q;
		cur_skip   = first_byte_s1 ? 32'd0   : skip_q;
		cur_fmt    = first_byte_s1 ? 16'd0   : fmt_q;
		cur_chan   = first_byte_s1 ? 16'd0   : chan_q;
		cur_rate   = first_byte_s1 ? 32'd0   : rate_q;
		cur_bits   = first_byte_s1 ? 16'd0   : bits_q;
		cur_seen   = first_byte_s1 ? 1'b0    : seen_q;
		cur_stereo = first_byte_s1 ? 1'b0    : stereo_q;

		nxt_phase  = cur_phase;
		nxt_pos    = cur_pos;
		nxt_tag    = cur_tag;
		nxt_len    = cur_len;
		nxt_skip   = cur_skip;
		nxt_fmt    = cur_fmt;
		nxt_chan   = cur_chan;
		nxt_rate   = cur_rate;
		nxt_bits   = cur_bits;
		nxt_seen   = cur_seen;
		nxt_stereo = cur_stereo;

		hdr_pos  = cur_pos[2:0];
		skip_dec = cur_skip - 32'd1;
		fmt_ok   = 1'b0;

		if (cur_phase != PH_DONE && cur_phase != PH_ERR) begin
			if (eos_s1) begin
				nxt_phase = PH_ERR;
			end else begin
				case (cur_phase)
					PH_RIFF: begin
						// Size bytes at offsets four to seven are not checked
						if ((cur_pos inside {[4'd0:4'd3], [4'd8:4'd11]}) &&
							data_byte_s1 != riff_want(cur_pos)) begin
							nxt_phase = PH_ERR;
						end else if (cur_pos >= RIFF_LAST) begin
							nxt_phase = PH_HDR;
							nxt_pos   = 4'd0;
						end else begin
							nxt_pos = cur_pos + 4'd1;
						end
					end
					PH_HDR: begin
						// Tag then little-endian length; lanes above the first are
						// already clear
						case (hdr_pos)
							3'd0:    nxt_tag = {24'd0, data_byte_s1};
							3'd1:    nxt_tag[15:8] = data_byte_s1;
							3'd2:    nxt_tag[23:16] = data_byte_s1;
							3'd3:    nxt_tag[31:24] = data_byte_s1;
							3'd4:    nxt_len = {24'd0, data_byte_s1};
							3'd5:    nxt_len[15:8] = data_byte_s1;
							3'd6:    nxt_len[23:16] = data_byte_s1;
							default: nxt_len[31:24] = data_byte_s1;
						endcase
						if (hdr_pos == HDR_LAST) begin
							nxt_pos = 4'd0;
							if (nxt_tag == TAG_FMT) begin
								nxt_phase = (nxt_len < FMT_LEN) ? PH_ERR : PH_FMT;
							end else if (nxt_tag == TAG_DATA) begin
								nxt_phase = cur_seen ? PH_DONE : PH_ERR;
							end else if (nxt_len == 32'd0) begin
								nxt_phase = PH_HDR;
							end else begin
								nxt_skip  = nxt_len;
								nxt_phase = PH_SKIP;
							end
						end else begin
							nxt_pos = {1'b0, hdr_pos} + 4'd1;
						end
					end
					PH_FMT: begin
						case (cur_pos)
							4'd0:    nxt_fmt = {8'd0, data_byte_s1};
							4'd1:    nxt_fmt[15:8] = data_byte_s1;
							4'd2:    nxt_chan = {8'd0, data_byte_s1};
							4'd3:    nxt_chan[15:8] = data_byte_s1;
							4'd4:    nxt_rate = {24'd0, data_byte_s1};
							4'd5:    nxt_rate[15:8] = data_byte_s1;
							4'd6:    nxt_rate[23:16] = data_byte_s1;
							4'd7:    nxt_rate[31:24] = data_byte_s1;
							4'd14:   nxt_bits = {8'd0, data_byte_s1};
							4'd15:   nxt_bits[15:8] = data_byte_s1;
							default: nxt_fmt = cur_fmt;
						endcase
						if (cur_pos != FMT_LAST) begin
							nxt_pos = cur_pos + 4'd1;
						end else begin
							// Format check on the last fixed fmt byte
							nxt_pos = 4'd0;
							fmt_ok = nxt_fmt == FMT_PCM && nxt_bits == BITS_16 &&
								(nxt_chan == CH_MONO || nxt_chan == CH_STEREO) &&
								nxt_rate >= cfg.min_rate && nxt_rate <= cfg.max_rate;
							if (!fmt_ok) begin
								nxt_phase = PH_ERR;
							end else begin
								nxt_stereo = (nxt_chan == CH_STEREO);
								nxt_seen   = 1'b1;
								nxt_skip   = cur_len - FMT_LEN;
								nxt_phase  = (cur_len != FMT_LEN) ? PH_SKIP : PH_HDR;
							end
						end
					end
					PH_SKIP: begin
						nxt_skip = skip_dec;
						if (skip_dec == 32'd0) begin
							nxt_phase = PH_HDR;
							nxt_pos   = 4'd0;
						end
					end
					default: nxt_phase = PH_ERR;
				endcase
			end
		end

		case (nxt_phase)
			PH_DONE: nxt_status = whp_pkg::ST_DONE;
			PH_ERR:  nxt_status = whp_pkg::ST_ERROR;
			default: nxt_status = whp_pkg::ST_PARSING;
		endcase
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			pos_q    <= 4'd0;
			tag_q    <= 32'd0;
			len_q    <= 32'd0;
			skip_q   <= 32'd0;
			fmt_q    <= 16'd0;
			chan_q   <= 16'd0;
			rate_q   <= 32'd0;
			bits_q   <= 16'd0;
			seen_q   <= 1'b0;
			stereo_q <= 1'b0;
		end else if (s1_fire) begin
			phase_q  <= nxt_phase;
			pos_q    <= nxt_pos;
			tag_q    <= nxt_tag;
			len_q    <= nxt_len;
			skip_q   <= nxt_skip;
			fmt_q    <= nxt_fmt;
			chan_q   <= nxt_chan;
			rate_q   <= nxt_rate;
			bits_q   <= nxt_bits;
			seen_q   <= nxt_seen;
			stereo_q <= nxt_stereo;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q     <= nxt_status;
			out_rate_q   <= (nxt_status == whp_pkg::ST_DONE) ? nxt_rate : 32'd0;
			out_stereo_q <= (nxt_status == whp_pkg::ST_DONE) && nxt_stereo;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.status  = status_q;
	assign result.rate_hz = out_rate_q;
	assign result.stereo  = out_stereo_q;

	// Success is only reachable after an accepted fmt chunk
	a_done_needs_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> seen_q)
		else $error("done phase without accepted fmt chunk");

	// A finished parse holds until a restart
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !first_byte_s1 && (phase_q == PH_DONE || phase_q == PH_ERR)
		|=> $stable(phase_q))
		else $error("finished parse left without restart");

	// Rate and stereo only reported on success
	a_fields_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != whp_pkg::ST_DONE |-> out_rate_q == 32'd0 && !out_stereo_q)
		else $error("format fields reported without success");

	// Chunk header offset stays inside the eight header bytes
	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HDR |-> pos_q < 4'd8)
		else $error("chunk header offset out of range");

	// A skip never sits at a zero count
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != 32'd0)
		else $error("skip phase with zero count");

endmodule

@@ sv/wav_header_parser.sv @@
// Top level of the WAV header parser: APB registers and byte parse engine.
// Takes one byte of a WAV file per clock on the stream channel while stream.ready is high,
// returns one result per byte on the result channel: an input register takes the byte, then
// the parse update goes into a result register. A byte can be taken in every cycle;
// stream.ready drops only while the result register holds a result that has not been taken
// and the input register is full. Status 0 means parsing, 1 means a data chunk was reached
// after an accepted PCM 16-bit mono or stereo fmt chunk (rate_hz and stereo are then valid),
// 2 means error; a final status holds until a byte with first_byte set restarts the parse.
// Rate limits sit at APB address 0 (min, reset 8000) and 4 (max, reset 48000); the user must
// write them only while the block is idle, which the block itself does not enforce.
module wav_header_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [whp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [whp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [whp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	whp_in_if.sink                         stream,
	whp_out_if.source                      result
);

	whp_pkg::cfg_t cfg;

	whp_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	whp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.stream (stream),
		.result (result)
	);

endmodule
